// ===== hw/rtl/dsr_pkg.sv =====
// Shared types, constants and codes for the depth range scaler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dsr_pkg;

   // Fixed-point formats
   localparam int COORD_FRAC_BITS = 16;
   localparam int DIR_FRAC_BITS   = 30;
   localparam int DEPTH_W         = 32;
   localparam int PROD_W          = 65;   // 32-bit coordinate times 33-bit negated direction
   localparam int ACC_W           = 67;   // sum of three products
   localparam int SHIFTED_W       = ACC_W - DIR_FRAC_BITS;
   localparam int DSUM_W          = SHIFTED_W + 1;

   // Scale numerator and quotient widths
   localparam longint SCALE_BASE   = 267175328;
   localparam int     SCALE_BASE_W = 28;
   localparam int     NUM_W        = SCALE_BASE_W + COORD_FRAC_BITS;
   localparam int     SCALE_W      = 44;
   localparam int     QUO_EXT_W    = (NUM_W > SCALE_W) ? NUM_W : SCALE_W;
   localparam int     SPAN_W       = 31;
   localparam int     CNT_W        = $clog2(NUM_W);

   localparam logic [NUM_W-1:0] SCALE_NUMER = NUM_W'(SCALE_BASE) << COORD_FRAC_BITS;
   localparam logic [QUO_EXT_W-1:0] SCALE_MAX = QUO_EXT_W'((65'd1 << SCALE_W) - 65'd1);

   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = 32'sh8000_0000;
   localparam logic signed [DEPTH_W-1:0] DEPTH_LSB = 32'sd1;

   // Result status codes
   localparam logic [1:0] STATUS_RANGE_SET  = 2'd0;
   localparam logic [1:0] STATUS_BEHIND     = 2'd1;
   localparam logic [1:0] STATUS_SPAN_SMALL = 2'd2;

   // Register map (index = byte address / 4)
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_VIEW_DIR_X   = 3'd0;
   localparam logic [2:0] REG_VIEW_DIR_Y   = 3'd1;
   localparam logic [2:0] REG_VIEW_DIR_Z   = 3'd2;
   localparam logic [2:0] REG_DEPTH_OFFSET = 3'd3;
   localparam logic [2:0] REG_SOLID_ONLY   = 3'd4;

   localparam logic signed [31:0] VIEW_DIR_Z_RESET = 32'sd1073741824;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic               object_ready;
      logic               object_transparent;
      logic               last_vertex;
   } req_data_type;

   typedef struct packed {
      logic [30:0]        near_offset;
      logic [SCALE_W-1:0] depth_scale;
      logic [1:0]         status;
   } rsp_data_type;

   typedef struct packed {
      logic signed [31:0] view_dir_x;
      logic signed [31:0] view_dir_y;
      logic signed [31:0] view_dir_z;
      logic signed [31:0] camera_depth_offset;
      logic               solid_only;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic     load;
      logic     mul_en;
      axis_type mul_sel;
      logic     acc_clr;
      logic     acc_en;
      logic     depth_en;
      logic     track_en;
      logic     eval_en;
      logic     div_step;
      logic     emit;
   } dsr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last;
      logic range_ok;
   } dsr_stat_type;

endpackage

// ===== hw/rtl/dsr_csr.sv =====
// Configuration register file of the depth range scaler, on an APB-style port.
// Depends on dsr_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module dsr_csr
   import dsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   // Write on the access phase of a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_dir_x          <= '0;
         cfg_ff.view_dir_y          <= '0;
         cfg_ff.view_dir_z          <= VIEW_DIR_Z_RESET;
         cfg_ff.camera_depth_offset <= '0;
         cfg_ff.solid_only          <= 1'b0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_VIEW_DIR_X:   cfg_ff.view_dir_x          <= pwdata;
            REG_VIEW_DIR_Y:   cfg_ff.view_dir_y          <= pwdata;
            REG_VIEW_DIR_Z:   cfg_ff.view_dir_z          <= pwdata;
            REG_DEPTH_OFFSET: cfg_ff.camera_depth_offset <= pwdata;
            REG_SOLID_ONLY:   cfg_ff.solid_only          <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_idx)
         REG_VIEW_DIR_X:   prdata = cfg_ff.view_dir_x;
         REG_VIEW_DIR_Y:   prdata = cfg_ff.view_dir_y;
         REG_VIEW_DIR_Z:   prdata = cfg_ff.view_dir_z;
         REG_DEPTH_OFFSET: prdata = cfg_ff.camera_depth_offset;
         REG_SOLID_ONLY:   prdata = {31'd0, cfg_ff.solid_only};
         default:          prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/dsr_datapath.sv =====
// Datapath of the depth range scaler: shared multiplier, depth accumulator,
// near/far tracking, range evaluation and restoring divider. Depends on dsr_pkg.
`timescale 1ns / 1ps

module dsr_datapath
   import dsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_data_type req_data,
   input  dsr_cmd_type  cmd,
   output dsr_stat_type stat,
   output logic         rsp_valid,
   output rsp_data_type rsp_data
);

   // Vertex hold registers
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic               counts_ff;
   logic               last_ff;

   // Arithmetic registers
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DEPTH_W-1:0] depth_ff;
   logic signed [DEPTH_W-1:0] near_ff, far_ff;

   // Evaluation and division registers
   logic [1:0]        status_ff;
   logic [30:0]       near_off_ff;
   logic [SPAN_W-1:0] span_ff;
   logic [SPAN_W-1:0] rem_ff;
   logic [NUM_W-1:0]  quo_ff;

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;

   logic signed [31:0]         coord_sel;
   logic signed [31:0]         dir_sel;
   logic signed [32:0]         dir_neg;
   logic signed [PROD_W-1:0]   prod_in;
   logic signed [DSUM_W-1:0]   dsum;
   logic signed [DEPTH_W-1:0]  depth_in;
   logic signed [DEPTH_W-1:0]  near_clamp;
   logic signed [DEPTH_W:0]    span_wide;
   logic                       far_pos;
   logic                       span_pos;
   logic [1:0]                 status_code;
   logic [SPAN_W:0]            div_shifted;
   logic [SPAN_W+1:0]          div_diff;
   logic [QUO_EXT_W-1:0]       quo_ext;
   logic [SCALE_W-1:0]         scale_sat;

   // Select one axis for the shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         AXIS_X: begin
            coord_sel = x_ff;
            dir_sel   = cfg.view_dir_x;
         end
         AXIS_Y: begin
            coord_sel = y_ff;
            dir_sel   = cfg.view_dir_y;
         end
         default: begin
            coord_sel = z_ff;
            dir_sel   = cfg.view_dir_z;
         end
      endcase
   end

   assign dir_neg = -{dir_sel[31], dir_sel};
   assign prod_in = coord_sel * dir_neg;

   // Floor shift of the exact sum, add offset, saturate to 32 bits
   assign dsum = {acc_ff[ACC_W-1], acc_ff[ACC_W-1:DIR_FRAC_BITS]}
                 + {{(DSUM_W-32){cfg.camera_depth_offset[31]}}, cfg.camera_depth_offset};

   always_comb begin
      if (dsum[DSUM_W-1:DEPTH_W-1] == '0 || dsum[DSUM_W-1:DEPTH_W-1] == '1) begin
         depth_in = dsum[DEPTH_W-1:0];
      end else if (dsum[DSUM_W-1]) begin
         depth_in = DEPTH_MIN;
      end else begin
         depth_in = DEPTH_MAX;
      end
   end

   // Range evaluation over the tracked depths
   assign far_pos    = far_ff >= DEPTH_LSB;
   assign near_clamp = (near_ff < DEPTH_LSB) ? DEPTH_LSB : near_ff;
   assign span_wide  = {far_ff[DEPTH_W-1], far_ff} - {near_clamp[DEPTH_W-1], near_clamp};
   assign span_pos   = span_wide > 0;

   always_comb begin
      if (!far_pos) begin
         status_code = STATUS_BEHIND;
      end else if (!span_pos) begin
         status_code = STATUS_SPAN_SMALL;
      end else begin
         status_code = STATUS_RANGE_SET;
      end
   end

   assign stat.last     = last_ff;
   assign stat.range_ok = far_pos & span_pos;

   // One restoring division step
   assign div_shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign div_diff    = {1'b0, div_shifted} - {2'b00, span_ff};

   // Saturate the quotient to the scale width
   assign quo_ext   = QUO_EXT_W'(quo_ff);
   assign scale_sat = (quo_ext > SCALE_MAX) ? SCALE_MAX[SCALE_W-1:0] : quo_ext[SCALE_W-1:0];

   // Vertex capture and arithmetic pipeline
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff      <= req_data.vert_x;
         y_ff      <= req_data.vert_y;
         z_ff      <= req_data.vert_z;
         counts_ff <= req_data.object_ready
                      & ~(cfg.solid_only & req_data.object_transparent);
         last_ff   <= req_data.last_vertex;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
      if (cmd.depth_en) begin
         depth_ff <= depth_in;
      end
   end

   // Track nearest and farthest depth; restart the scene on evaluation
   always_ff @(posedge clock) begin
      if (reset || cmd.eval_en) begin
         near_ff <= DEPTH_MAX;
         far_ff  <= DEPTH_MIN;
      end else if (cmd.track_en && counts_ff) begin
         if (depth_ff < near_ff) begin
            near_ff <= depth_ff;
         end
         if (depth_ff > far_ff) begin
            far_ff <= depth_ff;
         end
      end
   end

   // Evaluate the scene and run the divider
   always_ff @(posedge clock) begin
      if (cmd.eval_en) begin
         status_ff   <= status_code;
         near_off_ff <= near_clamp[30:0];
         span_ff     <= span_wide[SPAN_W-1:0];
         rem_ff      <= '0;
         quo_ff      <= SCALE_NUMER;
      end else if (cmd.div_step) begin
         if (!div_diff[SPAN_W+1]) begin
            rem_ff <= div_diff[SPAN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= div_shifted[SPAN_W-1:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   // Result register: one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_data_ff.status <= status_ff;
         if (status_ff == STATUS_RANGE_SET) begin
            rsp_data_ff.near_offset <= near_off_ff;
            rsp_data_ff.depth_scale <= scale_sat;
         end else begin
            rsp_data_ff.near_offset <= '0;
            rsp_data_ff.depth_scale <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/dsr_ctrl.sv =====
// Controller of the depth range scaler: sequences multiply, accumulate, depth, track,
// evaluate and divide steps. Depends on dsr_pkg for the command and status structs.
`timescale 1ns / 1ps

module dsr_ctrl
   import dsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dsr_stat_type stat,
   output dsr_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_DEPTH,
      S_TRACK,
      S_EVAL,
      S_DIV,
      S_DONE
   } state_type;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(2);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;

   // State, step counter and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         busy_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (start) begin
                  state_ff <= S_MUL;
                  busy_ff  <= 1'b1;
               end
            end
            S_MUL: begin
               if (cnt_ff == MUL_LAST) begin
                  state_ff <= S_ACC;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_ACC:   state_ff <= S_DEPTH;
            S_DEPTH: state_ff <= S_TRACK;
            S_TRACK: begin
               if (stat.last) begin
                  state_ff <= S_EVAL;
               end else begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_EVAL: begin
               cnt_ff   <= '0;
               state_ff <= stat.range_ok ? S_DIV : S_DONE;
            end
            S_DIV: begin
               if (cnt_ff == DIV_LAST) begin
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

   // Decode datapath commands from the state
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = axis_type'(cnt_ff[1:0]);
      case (state_ff)
         S_IDLE:  cmd.load = start;
         S_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_clr = (cnt_ff == '0);
            cmd.acc_en  = (cnt_ff != '0);
         end
         S_ACC:   cmd.acc_en   = 1'b1;
         S_DEPTH: cmd.depth_en = 1'b1;
         S_TRACK: cmd.track_en = 1'b1;
         S_EVAL:  cmd.eval_en  = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_DONE:  cmd.emit     = 1'b1;
         default: cmd          = '0;
      endcase
   end

endmodule

// ===== hw/rtl/depth_range_scaler.sv =====
// Depth range scaler: per-scene nearest/farthest depth and depth scale.
// Each vertex holds busy through three shared multiplies, accumulate, depth and track;
// a new vertex is taken only while busy is low. On the last vertex the controller
// evaluates the range, runs the one-bit-per-cycle restoring divider (44 quotient bits
// at Q16.16) only if the range is set, then emits the strobe. Reset (synchronous)
// restores config, controller and strobe, clears the scene; no stall on results.
`timescale 1ns / 1ps

module depth_range_scaler
   import dsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // vertex transfer
   input  logic                  start,
   output logic                  busy,
   input  req_data_type          req_data,
   // result transfer
   output logic                  rsp_valid,
   output rsp_data_type          rsp_data,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type      cfg;
   dsr_cmd_type  cmd;
   dsr_stat_type stat;

   dsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dsr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   dsr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // An accepted vertex always holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted vertex");

   // Result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result only ends a period of work
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

   // Offset and scale are zero unless the range is set
   a_zero_unless_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_RANGE_SET)
         |-> (rsp_data.near_offset == '0 && rsp_data.depth_scale == '0))
      else $error("non-zero offset or scale without a range");

endmodule
